/* hdl/x86_instruction_length_decoder_assert.svh */
// Assertion macros for the x86 instruction length decoder.
// Included by the top level; depends on nothing else.
`ifndef X86_INSTRUCTION_LENGTH_DECODER_ASSERT_SVH
`define X86_INSTRUCTION_LENGTH_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define ILD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ILD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ILD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ILD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/ild_pkg.sv */
// Package for the x86 instruction length decoder: opcode format ROMs,
// format codes and the decode result type. Depends on nothing.
package ild_pkg;

    localparam logic [7:0] PREFIX_OPSIZE = 8'h66;
    localparam logic [7:0] ESCAPE_0F     = 8'h0f;
    localparam logic [3:0] FMT_ERR       = 4'h9;

    // Mode field, bits 1:0 of a format code.
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_ADDR  = 2'd1;
    localparam logic [1:0] MODE_MODRM = 2'd2;
    localparam logic [1:0] MODE_GROUP = 2'd3;

    // Operand type field, bits 3:2 of a format code.
    localparam logic [1:0] TYPE_NONE  = 2'd0;
    localparam logic [1:0] TYPE_BYTE  = 2'd1;
    localparam logic [1:0] TYPE_DWORD = 2'd2;
    localparam logic [1:0] TYPE_WORD  = 2'd3;

    localparam logic [3:0] ONE_BYTE_ROM [256] = '{
        2,2,2,2,4,8,0,0,2,2,2,2,4,8,0,0,
        2,2,2,2,4,8,0,0,2,2,2,2,4,8,0,0,
        2,2,2,2,4,8,0,0,2,2,2,2,4,8,0,0,
        2,2,2,2,4,8,0,0,2,2,2,2,4,8,0,0,
        0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,
        0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,0,
        0,0,2,2,0,0,0,0,8,10,4,6,0,0,0,0,
        5,5,5,5,5,5,5,5,5,5,5,5,5,5,5,5,
        6,10,6,6,2,2,2,2,2,2,2,2,2,2,2,2,
        0,0,0,0,0,0,0,0,0,0,9,0,0,0,0,0,
        1,1,1,1,0,0,0,0,4,8,0,0,0,0,0,0,
        4,4,4,4,4,4,4,4,8,8,8,8,8,8,8,8,
        6,6,12,0,2,2,6,10,9,0,12,0,0,4,9,0,
        2,2,2,2,4,4,0,0,2,2,2,2,2,2,2,2,
        5,5,5,5,4,4,4,4,13,13,1,5,0,0,0,0,
        0,9,0,0,0,0,3,3,0,0,0,0,0,0,3,3
    };

    localparam logic [3:0] TWO_BYTE_ROM [256] = '{
        9,9,9,9,9,9,9,9,9,9,9,9,9,9,9,9,
        2,2,2,2,2,2,2,2,9,9,9,9,9,9,9,9,
        2,2,2,2,9,9,9,9,9,9,9,9,9,9,9,9,
        0,0,0,0,9,9,9,9,9,9,9,9,9,9,9,9,
        2,2,2,2,2,2,2,2,2,2,2,2,2,2,2,2,
        9,9,9,9,9,9,9,9,9,9,9,9,9,9,9,9,
        2,2,2,2,2,2,2,2,2,2,2,2,2,2,2,2,
        6,6,6,6,2,2,2,0,9,9,9,9,9,9,2,2,
        13,13,13,13,13,13,13,13,13,13,13,13,13,13,13,13,
        2,2,2,2,2,2,2,2,2,2,2,2,2,2,2,2,
        0,0,0,2,6,2,2,2,9,9,9,2,6,2,9,2,
        2,2,2,2,2,2,2,2,9,9,9,2,2,2,2,2,
        2,2,2,2,2,2,2,2,0,0,0,0,0,0,0,0,
        2,2,2,2,2,2,2,2,2,2,2,2,2,2,2,2,
        2,2,2,2,2,2,2,2,2,2,2,2,2,2,2,2,
        2,2,2,2,2,2,2,2,2,2,2,2,2,2,2,9
    };

    localparam logic [3:0] GROUP_ROM [32] = '{
        6,9,2,2,2,2,2,2,10,9,2,2,2,2,2,2,
        2,2,9,9,9,9,9,9,2,2,2,9,2,9,2,9
    };

    // Decoded parts of one instruction.
    typedef struct packed {
        logic [3:0] total_length;
        logic       invalid;
        logic       has_size_prefix;
        logic       two_byte_opcode;
        logic       has_modrm;
        logic       has_sib;
        logic [2:0] displacement_bytes;
        logic [2:0] trailing_bytes;
    } t_result;

endpackage

/* hdl/ild_decode.sv */
// Combinational length decode of one five-byte instruction window.
// Depends on ild_pkg for the format ROMs and the result type.
module ild_decode (
    input  logic [7:0]       i_byte0,
    input  logic [7:0]       i_byte1,
    input  logic [7:0]       i_byte2,
    input  logic [7:0]       i_byte3,
    input  logic [7:0]       i_byte4,
    output ild_pkg::t_result o_result
);
    import ild_pkg::*;

    logic       pfx;
    logic       esc;
    logic [7:0] code;
    logic [7:0] second;
    logic [7:0] modrm;
    logic [7:0] sib;
    logic [3:0] fmt_base;
    logic [3:0] fmt;
    logic       err;
    logic       hm;
    logic       hs;
    logic [2:0] disp;
    logic [2:0] trail;

    // Prefix and escape detection; pick the opcode, ModRM and SIB bytes.
    always_comb begin
        pfx    = (i_byte0 == PREFIX_OPSIZE);
        code   = pfx ? i_byte1 : i_byte0;
        second = pfx ? i_byte2 : i_byte1;
        esc    = (code == ESCAPE_0F);
        case ({pfx, esc})
            2'b00:   begin modrm = i_byte1; sib = i_byte2; end
            2'b11:   begin modrm = i_byte3; sib = i_byte4; end
            default: begin modrm = i_byte2; sib = i_byte3; end
        endcase
    end

    // Format lookup, with the group ROM indexed by two opcode bits and ModRM.reg.
    always_comb begin
        fmt_base = esc ? TWO_BYTE_ROM[second] : ONE_BYTE_ROM[code];
        if (fmt_base[1:0] == MODE_GROUP) begin
            fmt = GROUP_ROM[{code[3], code[0], modrm[5:3]}];
        end else begin
            fmt = fmt_base;
        end
        err = (fmt == FMT_ERR);
    end

    // Addressing bytes and operand bytes.
    always_comb begin
        hm   = 1'b0;
        hs   = 1'b0;
        disp = 3'd0;
        if (!err && fmt[1]) begin
            hm = 1'b1;
            hs = (modrm[2:0] == 3'd4) && (modrm[7:6] != 2'b11);
            if (modrm[7:6] == 2'b01) begin
                disp = 3'd1;
            end else if ((modrm[7:6] == 2'b10) ||
                         (modrm[7:6] == 2'b00 && modrm[2:0] == 3'd5) ||
                         (modrm[7:6] == 2'b00 && hs && sib[2:0] == 3'd5)) begin
                disp = 3'd4;
            end
        end
        trail = 3'd0;
        if (!err) begin
            if (fmt[1:0] == MODE_ADDR) begin
                case (fmt[3:2])
                    TYPE_NONE: trail = 3'd4;
                    TYPE_BYTE: trail = 3'd1;
                    TYPE_WORD: trail = 3'd4;
                    default:   trail = 3'd0;
                endcase
            end else begin
                case (fmt[3:2])
                    TYPE_BYTE:  trail = 3'd1;
                    TYPE_DWORD: trail = pfx ? 3'd2 : 3'd4;
                    TYPE_WORD:  trail = 3'd2;
                    default:    trail = 3'd0;
                endcase
            end
        end
    end

    // Assemble the result.
    always_comb begin
        o_result.invalid            = err;
        o_result.has_size_prefix    = pfx;
        o_result.two_byte_opcode    = esc;
        o_result.has_modrm          = hm;
        o_result.has_sib            = hs;
        o_result.displacement_bytes = disp;
        o_result.trailing_bytes     = trail;
        if (err) begin
            o_result.total_length = 4'd1;
        end else begin
            o_result.total_length = 4'd1 + {3'd0, pfx} + {3'd0, esc} + {3'd0, hm}
                                  + {3'd0, hs} + {1'b0, disp} + {1'b0, trail};
        end
    end

endmodule

/* hdl/x86_instruction_length_decoder.sv */
// Top level of the x86 instruction length decoder: input and result registers
// around ild_decode. Depends on ild_pkg and the assertion macro header.
//
// One instruction window is taken in every cycle in which start is high; busy
// is always low. Each result appears on the result ports with o_valid high for
// one cycle, after passing through the input register and then the table decode
// into the result register. Results come out in start order, and the receiver
// cannot stall them.
`include "x86_instruction_length_decoder_assert.svh"
module x86_instruction_length_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_window_byte0,
    input  logic [7:0] i_window_byte1,
    input  logic [7:0] i_window_byte2,
    input  logic [7:0] i_window_byte3,
    input  logic [7:0] i_window_byte4,
    output logic       o_valid,
    output logic [3:0] o_total_length,
    output logic       o_invalid,
    output logic       o_has_size_prefix,
    output logic       o_two_byte_opcode,
    output logic       o_has_modrm,
    output logic       o_has_sib,
    output logic [2:0] o_displacement_bytes,
    output logic [2:0] o_trailing_bytes
);
    import ild_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_b0, r_b1, r_b2, r_b3, r_b4;
    logic       r_out_valid;
    t_result    r_out;
    t_result    n_out;

    assign busy = 1'b0;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start;
        end
        if (start) begin
            r_b0 <= i_window_byte0;
            r_b1 <= i_window_byte1;
            r_b2 <= i_window_byte2;
            r_b3 <= i_window_byte3;
            r_b4 <= i_window_byte4;
        end
    end

    ild_decode u_decode (
        .i_byte0  (r_b0),
        .i_byte1  (r_b1),
        .i_byte2  (r_b2),
        .i_byte3  (r_b3),
        .i_byte4  (r_b4),
        .o_result (n_out)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
        if (r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_total_length       = r_out.total_length;
    assign o_invalid            = r_out.invalid;
    assign o_has_size_prefix    = r_out.has_size_prefix;
    assign o_two_byte_opcode    = r_out.two_byte_opcode;
    assign o_has_modrm          = r_out.has_modrm;
    assign o_has_sib            = r_out.has_sib;
    assign o_displacement_bytes = r_out.displacement_bytes;
    assign o_trailing_bytes     = r_out.trailing_bytes;

    // Checks on the pipeline and on the decoded result.
    `ILD_ASSERT_NEXT(a_in_follows_start, i_clk, i_rst_n, start, r_in_valid)
    `ILD_ASSERT_NEXT(a_out_follows_in, i_clk, i_rst_n, r_in_valid, o_valid)
    `ILD_ASSERT_IMPL(a_invalid_len_one, i_clk, i_rst_n, o_valid && o_invalid,
                     o_total_length == 4'd1 && !o_has_modrm && o_trailing_bytes == 3'd0)
    `ILD_ASSERT_IMPL(a_sib_needs_modrm, i_clk, i_rst_n, o_valid && o_has_sib, o_has_modrm)

endmodule

/* tb/tb_x86_instruction_length_decoder.sv */
// Self-checking testbench for the x86 instruction length decoder.
// Depends on ild_pkg and the x86_instruction_length_decoder top level.
module tb_x86_instruction_length_decoder;

    import ild_pkg::*;

    localparam int CLK_PERIOD = 12;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [7:0] i_window_byte0;
    logic [7:0] i_window_byte1;
    logic [7:0] i_window_byte2;
    logic [7:0] i_window_byte3;
    logic [7:0] i_window_byte4;
    logic       o_valid;
    logic [3:0] o_total_length;
    logic       o_invalid;
    logic       o_has_size_prefix;
    logic       o_two_byte_opcode;
    logic       o_has_modrm;
    logic       o_has_sib;
    logic [2:0] o_displacement_bytes;
    logic [2:0] o_trailing_bytes;

    // Decodes still owed by the block, oldest first.
    t_result pending_decodes[$];
    int      error_count = 0;

    x86_instruction_length_decoder u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_window_byte0      (i_window_byte0),
        .i_window_byte1      (i_window_byte1),
        .i_window_byte2      (i_window_byte2),
        .i_window_byte3      (i_window_byte3),
        .i_window_byte4      (i_window_byte4),
        .o_valid             (o_valid),
        .o_total_length      (o_total_length),
        .o_invalid           (o_invalid),
        .o_has_size_prefix   (o_has_size_prefix),
        .o_two_byte_opcode   (o_two_byte_opcode),
        .o_has_modrm         (o_has_modrm),
        .o_has_sib           (o_has_sib),
        .o_displacement_bytes(o_displacement_bytes),
        .o_trailing_bytes    (o_trailing_bytes)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Works out the length and parts of the instruction at the window start.
    function automatic t_result decode_length(input logic [7:0] b0, input logic [7:0] b1,
                                              input logic [7:0] b2, input logic [7:0] b3,
                                              input logic [7:0] b4);
        logic [7:0] w [5];
        int         pos;
        logic [7:0] opcode;
        logic [7:0] modrm;
        logic [7:0] sib;
        logic [3:0] fmt;
        t_result    r;
        w[0] = b0; w[1] = b1; w[2] = b2; w[3] = b3; w[4] = b4;
        r = '0;
        r.has_size_prefix = (b0 == PREFIX_OPSIZE);
        pos = r.has_size_prefix ? 1 : 0;
        opcode = w[pos];
        pos++;
        r.two_byte_opcode = (opcode == ESCAPE_0F);
        if (r.two_byte_opcode) begin
            fmt = TWO_BYTE_ROM[w[pos]];
            pos++;
        end else begin
            fmt = ONE_BYTE_ROM[opcode];
        end
        // Group opcodes take their format from ModRM.reg and two opcode bits.
        if (fmt[1:0] == MODE_GROUP) begin
            fmt = GROUP_ROM[{opcode[3], opcode[0], w[pos][5:3]}];
        end
        if (fmt == FMT_ERR) begin
            r.invalid = 1'b1;
            r.total_length = 4'd1;
            return r;
        end
        // Addressing bytes: ModRM, SIB and displacement.
        if (fmt[1]) begin
            r.has_modrm = 1'b1;
            modrm = w[pos];
            sib = 8'h00;
            if (modrm[2:0] == 3'd4 && modrm[7:6] != 2'b11) begin
                r.has_sib = 1'b1;
                sib = w[pos + 1];
            end
            if (modrm[7:6] == 2'b01) begin
                r.displacement_bytes = 3'd1;
            end else if (modrm[7:6] == 2'b10 || (modrm[7:6] == 2'b00 && modrm[2:0] == 3'd5)
                         || (modrm[7:6] == 2'b00 && r.has_sib && sib[2:0] == 3'd5)) begin
                r.displacement_bytes = 3'd4;
            end
        end
        // Operand bytes after the addressing bytes.
        if (fmt[1:0] == MODE_ADDR) begin
            case (fmt[3:2])
                TYPE_NONE: r.trailing_bytes = 3'd4;
                TYPE_BYTE: r.trailing_bytes = 3'd1;
                TYPE_WORD: r.trailing_bytes = 3'd4;
                default:   r.trailing_bytes = 3'd0;
            endcase
        end else begin
            case (fmt[3:2])
                TYPE_BYTE:  r.trailing_bytes = 3'd1;
                TYPE_DWORD: r.trailing_bytes = r.has_size_prefix ? 3'd2 : 3'd4;
                TYPE_WORD:  r.trailing_bytes = 3'd2;
                default:    r.trailing_bytes = 3'd0;
            endcase
        end
        r.total_length = 4'(1 + r.has_size_prefix + r.two_byte_opcode + r.has_modrm
                            + r.has_sib + r.displacement_bytes + r.trailing_bytes);
        return r;
    endfunction

    // Sends one window and waits for its start transaction, then may idle for a random gap.
    task automatic send_window(input logic [7:0] b0, input logic [7:0] b1,
                               input logic [7:0] b2, input logic [7:0] b3,
                               input logic [7:0] b4);
        int gap;
        start <= 1'b1;
        i_window_byte0 <= b0;
        i_window_byte1 <= b1;
        i_window_byte2 <= b2;
        i_window_byte3 <= b3;
        i_window_byte4 <= b4;
        do @(posedge i_clk); while (busy);
        pending_decodes.push_back(decode_length(b0, b1, b2, b3, b4));
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_decodes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input int expected, input int actual);
        if (expected != actual) begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            error_count++;
        end
    endtask

    // Compares each result transaction with the oldest pending decode.
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_valid) begin
            if (pending_decodes.size() == 0) begin
                $error("result transaction with no pending decode");
                error_count++;
            end else begin
                exp_r = pending_decodes.pop_front();
                check_field("total_length", exp_r.total_length, o_total_length);
                check_field("invalid", exp_r.invalid, o_invalid);
                check_field("has_size_prefix", exp_r.has_size_prefix, o_has_size_prefix);
                check_field("two_byte_opcode", exp_r.two_byte_opcode, o_two_byte_opcode);
                check_field("has_modrm", exp_r.has_modrm, o_has_modrm);
                check_field("has_sib", exp_r.has_sib, o_has_sib);
                check_field("displacement_bytes", exp_r.displacement_bytes,
                            o_displacement_bytes);
                check_field("trailing_bytes", exp_r.trailing_bytes, o_trailing_bytes);
            end
        end
    end

    // Byte extremes, prefix and escape handling, groups, addressing forms.
    task automatic test_directed();
        send_window(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_window(8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
        send_window(8'h66, 8'h66, 8'h00, 8'h00, 8'h00); // doubled prefix
        send_window(8'h0f, 8'h00, 8'h00, 8'h00, 8'h00); // invalid two-byte opcode
        send_window(8'h66, 8'h0f, 8'hff, 8'h00, 8'h00); // invalid, prefix and escape seen
        send_window(8'h9a, 8'h12, 8'h34, 8'h56, 8'h78); // invalid one-byte opcode
        send_window(8'h0f, 8'h84, 8'h00, 8'h00, 8'h00); // relative dword
        send_window(8'h66, 8'h0f, 8'h84, 8'h00, 8'h00); // relative stays dword
        send_window(8'ha0, 8'h00, 8'h00, 8'h00, 8'h00); // absolute address
        send_window(8'h66, 8'ha1, 8'h00, 8'h00, 8'h00); // address ignores prefix
        send_window(8'heb, 8'h10, 8'h00, 8'h00, 8'h00); // relative byte
        send_window(8'h68, 8'h00, 8'h00, 8'h00, 8'h00); // dword immediate
        send_window(8'h66, 8'h68, 8'h00, 8'h00, 8'h00); // immediate shrunk by prefix
        send_window(8'hc2, 8'h00, 8'h00, 8'h00, 8'h00); // word immediate
        send_window(8'hf7, 8'h05, 8'h00, 8'h00, 8'h00); // test r/m32, imm32, disp32
        send_window(8'h66, 8'hf7, 8'hc0, 8'h00, 8'h00); // test with prefix
        send_window(8'hf6, 8'h08, 8'h00, 8'h00, 8'h00); // invalid group entry
        send_window(8'hff, 8'h38, 8'h00, 8'h00, 8'h00); // invalid group entry
        send_window(8'h8b, 8'h04, 8'h25, 8'h00, 8'h00); // SIB with base 5, mod 0
        send_window(8'h8b, 8'h44, 8'h24, 8'h08, 8'h00); // SIB with disp8
        send_window(8'h8b, 8'h84, 8'h24, 8'h00, 8'h00); // SIB with disp32
        send_window(8'h8b, 8'hc4, 8'h00, 8'h00, 8'h00); // register, no SIB
        send_window(8'h66, 8'h0f, 8'hb6, 8'h04, 8'h25); // longest SIB position
        send_window(8'h69, 8'h84, 8'h24, 8'h00, 8'h00); // longest instruction
    endtask

    // Mostly well-formed windows with random content, some pure noise.
    task automatic test_random(input int count);
        logic [7:0] b [5];
        int         kind;
        for (int n = 0; n < count; n++) begin
            for (int k = 0; k < 5; k++) b[k] = 8'($urandom);
            kind = $urandom_range(0, 9);
            if (kind < 2) begin
                b[0] = PREFIX_OPSIZE;
                if (kind == 1) b[1] = ESCAPE_0F;
            end else if (kind < 4) begin
                b[0] = ESCAPE_0F;
            end else if (kind < 6) begin
                b[0] = {7'b1111_011, 1'($urandom)} | (($urandom_range(0, 1) != 0) ? 8'h08 : 8'h00);
                b[1] = {b[1][7:6], b[1][5:3], ($urandom_range(0, 1) != 0) ? 3'd4 : b[1][2:0]};
            end else if (kind < 8) begin
                // ModRM with rm 4, so mostly with SIB, biased toward base 5.
                b[0] = ($urandom_range(0, 1) != 0) ? 8'h8b : 8'h69;
                b[1] = {b[1][7:6] & 2'b10 | b[1][7:6], b[1][5:3], 3'd4};
                if ($urandom_range(0, 1) != 0) b[2][2:0] = 3'd5;
            end
            send_window(b[0], b[1], b[2], b[3], b[4]);
        end
    endtask

    // Sender holds off until the block has returned every decode.
    task automatic test_drain_pause();
        test_random(20);
        wait_drained();
        test_random(20);
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_window_byte0 <= 8'h00;
        i_window_byte1 <= 8'h00;
        i_window_byte2 <= 8'h00;
        i_window_byte3 <= 8'h00;
        i_window_byte4 <= 8'h00;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(230);
        test_drain_pause();
        test_random(230);
        wait_drained();
        if (error_count == 0 && pending_decodes.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Hard stop in case results never arrive.
    initial begin
        #(CLK_PERIOD * 200000);
        $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/ild_pkg.sv
hdl/ild_decode.sv
hdl/x86_instruction_length_decoder.sv
tb/tb_x86_instruction_length_decoder.sv
